// File: design/lzsg_pkg.sv
// lzsg_pkg: shared types and constants for the lidar zone speed guard
// used by the top level and by its port checker; no dependencies

package lzsg_pkg;

  // sample range limits in mm
  localparam logic [15:0] MIN_RANGE_MM    = 16'd50;
  localparam logic [15:0] IGNORE_RANGE_MM = 16'd2000;

  // field and datapath widths
  localparam int RANGE_W  = 16;
  localparam int TRIG_W   = 16;
  localparam int OFFS_W   = 13;
  localparam int HALF_W   = 14;
  localparam int UNC_W    = 10;
  localparam int DIST_W   = RANGE_W + 1;
  localparam int PROD_W   = DIST_W + TRIG_W;
  localparam int FRAC_W   = 15;
  localparam int PROJ_W   = PROD_W - FRAC_W;
  localparam int POINT_W  = PROJ_W + 1;
  localparam int S_DATA_W = 56;
  localparam int M_DATA_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIDAR_OFFSET_X    = 3'd0,
    REG_STOP_HALF_X       = 3'd1,
    REG_STOP_HALF_Y       = 3'd2,
    REG_SLOW_HALF_X       = 3'd3,
    REG_SLOW_HALF_Y       = 3'd4,
    REG_NORMAL_HALF_X     = 3'd5,
    REG_NORMAL_HALF_Y     = 3'd6,
    REG_RANGE_UNCERTAINTY = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_FAST   = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_SLOW   = 2'd2
  } speed_mode_t;

  // reset values of the configuration registers
  localparam logic [OFFS_W-1:0] RST_LIDAR_OFFSET_X    = 13'd70;
  localparam logic [HALF_W-1:0] RST_STOP_HALF_X       = 14'd750;
  localparam logic [HALF_W-1:0] RST_STOP_HALF_Y       = 14'd350;
  localparam logic [HALF_W-1:0] RST_SLOW_HALF_X       = 14'd0;
  localparam logic [HALF_W-1:0] RST_SLOW_HALF_Y       = 14'd300;
  localparam logic [HALF_W-1:0] RST_NORMAL_HALF_X     = 14'd0;
  localparam logic [HALF_W-1:0] RST_NORMAL_HALF_Y     = 14'd700;
  localparam logic [UNC_W-1:0]  RST_RANGE_UNCERTAINTY = 10'd63;

endpackage

// File: design/lidar_zone_speed_guard.sv
// lidar_zone_speed_guard: per-scan protective field monitor for a planar lidar
// depends on lzsg_pkg
// a last-sample beat gives its result through the input, projection and box test registers, then the result register
// throughput: one sample beat per cycle; stalls only when a result waits unread
// the three stages are input register, projection multiply, box test with scan state
// reset: synchronous, clears all stage valids and scan state, restores register defaults

module lidar_zone_speed_guard (
  input  logic                               clk,
  input  logic                               rst,
  // range_mm[15:0], no_return[16], cos_angle[32:17], sin_angle[48:33], zero pad
  input  logic [lzsg_pkg::S_DATA_W-1:0]      s_tdata,
  input  logic                               s_tlast,   // last_sample
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // runstop[0], speed_mode[2:1], zero pad
  output logic [lzsg_pkg::M_DATA_W-1:0]      m_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lzsg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lzsg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int RW = lzsg_pkg::RANGE_W;
  localparam int TW = lzsg_pkg::TRIG_W;
  localparam int PW = lzsg_pkg::POINT_W;
  localparam int XW = lzsg_pkg::PROD_W;

  // configuration registers
  logic [lzsg_pkg::OFFS_W-1:0] lidar_offset_x;
  logic [lzsg_pkg::HALF_W-1:0] stop_half_x;
  logic [lzsg_pkg::HALF_W-1:0] stop_half_y;
  logic [lzsg_pkg::HALF_W-1:0] slow_half_x;
  logic [lzsg_pkg::HALF_W-1:0] slow_half_y;
  logic [lzsg_pkg::HALF_W-1:0] normal_half_x;
  logic [lzsg_pkg::HALF_W-1:0] normal_half_y;
  logic [lzsg_pkg::UNC_W-1:0]  range_uncertainty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lidar_offset_x    <= lzsg_pkg::RST_LIDAR_OFFSET_X;
      stop_half_x       <= lzsg_pkg::RST_STOP_HALF_X;
      stop_half_y       <= lzsg_pkg::RST_STOP_HALF_Y;
      slow_half_x       <= lzsg_pkg::RST_SLOW_HALF_X;
      slow_half_y       <= lzsg_pkg::RST_SLOW_HALF_Y;
      normal_half_x     <= lzsg_pkg::RST_NORMAL_HALF_X;
      normal_half_y     <= lzsg_pkg::RST_NORMAL_HALF_Y;
      range_uncertainty <= lzsg_pkg::RST_RANGE_UNCERTAINTY;
    end else if (cfg_valid && cfg_ready) begin
      unique case (lzsg_pkg::cfg_reg_t'(cfg_index))
        lzsg_pkg::REG_LIDAR_OFFSET_X:    lidar_offset_x    <= cfg_data[lzsg_pkg::OFFS_W-1:0];
        lzsg_pkg::REG_STOP_HALF_X:       stop_half_x       <= cfg_data;
        lzsg_pkg::REG_STOP_HALF_Y:       stop_half_y       <= cfg_data;
        lzsg_pkg::REG_SLOW_HALF_X:       slow_half_x       <= cfg_data;
        lzsg_pkg::REG_SLOW_HALF_Y:       slow_half_y       <= cfg_data;
        lzsg_pkg::REG_NORMAL_HALF_X:     normal_half_x     <= cfg_data;
        lzsg_pkg::REG_NORMAL_HALF_Y:     normal_half_y     <= cfg_data;
        lzsg_pkg::REG_RANGE_UNCERTAINTY: range_uncertainty <= cfg_data[lzsg_pkg::UNC_W-1:0];
        default: ;
      endcase
    end
  end

  // stage a: input register
  logic                 a_valid;
  logic [RW-1:0]        a_range;
  logic                 a_no_return;
  logic signed [TW-1:0] a_cos;
  logic signed [TW-1:0] a_sin;
  logic                 a_last;

  // stage b: projected point
  logic                                   b_valid;
  logic                                   b_use;
  logic                                   b_last;
  logic signed [lzsg_pkg::PROJ_W-1:0]     b_px;
  logic signed [lzsg_pkg::PROJ_W-1:0]     b_py;

  // stage c: box test and scan state
  logic c_valid;
  logic c_use;
  logic c_last;
  logic signed [lzsg_pkg::PROJ_W-1:0]     c_px;
  logic signed [lzsg_pkg::PROJ_W-1:0]     c_py;

  logic                   scan_stopped, scan_stopped_next;
  lzsg_pkg::speed_mode_t  scan_mode, scan_mode_next;
  logic                   res_stopped;
  lzsg_pkg::speed_mode_t  res_mode;

  logic out_free, c_go, c_ready, b_ready, a_ready;

  assign out_free = !m_tvalid || m_tready;
  assign c_go     = c_valid && (!c_last || out_free);
  assign c_ready  = !c_valid || c_go;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign s_tready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && s_tvalid) begin
      a_range     <= s_tdata[RW-1:0];
      a_no_return <= s_tdata[RW];
      a_cos       <= s_tdata[RW+TW:RW+1];
      a_sin       <= s_tdata[RW+2*TW:RW+TW+1];
      a_last      <= s_tlast;
    end
  end

  // projection
  logic signed [lzsg_pkg::DIST_W-1:0] dist_mm;
  logic signed [lzsg_pkg::PROD_W-1:0] prod_x, prod_y;
  logic                               a_use;

  always_comb begin
    dist_mm = signed'({1'b0, a_range}) -
              signed'({{(lzsg_pkg::DIST_W-lzsg_pkg::UNC_W){1'b0}}, range_uncertainty});
    prod_x  = XW'(dist_mm) * XW'(a_cos);
    prod_y  = XW'(dist_mm) * XW'(a_sin);
    a_use   = !a_no_return && (a_range >= lzsg_pkg::MIN_RANGE_MM) &&
              (a_range <= lzsg_pkg::IGNORE_RANGE_MM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_use  <= a_use;
      b_last <= a_last;
      b_px   <= prod_x[lzsg_pkg::PROD_W-1:lzsg_pkg::FRAC_W];
      b_py   <= prod_y[lzsg_pkg::PROD_W-1:lzsg_pkg::FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_valid) begin
      c_use  <= b_use;
      c_last <= b_last;
      c_px   <= b_px;
      c_py   <= b_py;
    end
  end

  // box tests
  logic signed [PW-1:0] pt_x, pt_y;
  logic signed [PW-1:0] shx, shy, lhx, lhy, nhx, nhy;
  logic stop_hit, slow_hit, normal_hit, usable;
  lzsg_pkg::speed_mode_t mode_upd;

  always_comb begin
    pt_x = signed'({c_px[lzsg_pkg::PROJ_W-1], c_px}) +
           signed'({{(PW-lzsg_pkg::OFFS_W){lidar_offset_x[lzsg_pkg::OFFS_W-1]}},
                    lidar_offset_x});
    pt_y = signed'({c_py[lzsg_pkg::PROJ_W-1], c_py});
    shx  = signed'({{(PW-lzsg_pkg::HALF_W){1'b0}}, stop_half_x});
    shy  = signed'({{(PW-lzsg_pkg::HALF_W){1'b0}}, stop_half_y});
    lhx  = signed'({{(PW-lzsg_pkg::HALF_W){1'b0}}, slow_half_x});
    lhy  = signed'({{(PW-lzsg_pkg::HALF_W){1'b0}}, slow_half_y});
    nhx  = signed'({{(PW-lzsg_pkg::HALF_W){1'b0}}, normal_half_x});
    nhy  = signed'({{(PW-lzsg_pkg::HALF_W){1'b0}}, normal_half_y});

    stop_hit   = (pt_x >= -shx) && (pt_x <= shx) && (pt_y >= -shy) && (pt_y <= shy);
    slow_hit   = (pt_x > -lhx) && (pt_x < lhx) && (pt_y > -lhy) && (pt_y < lhy);
    normal_hit = (pt_x > -nhx) && (pt_x < nhx) && (pt_y > -nhy) && (pt_y < nhy);
    usable     = c_use && !scan_stopped;

    mode_upd = scan_mode;
    if (slow_hit) begin
      mode_upd = lzsg_pkg::MODE_SLOW;
    end
    if (normal_hit && (mode_upd != lzsg_pkg::MODE_SLOW)) begin
      mode_upd = lzsg_pkg::MODE_NORMAL;
    end

    res_stopped = scan_stopped;
    res_mode    = scan_mode;
    if (usable) begin
      if (stop_hit) begin
        res_stopped = 1'b1;
        res_mode    = lzsg_pkg::MODE_SLOW;
      end else begin
        res_mode = mode_upd;
      end
    end

    scan_stopped_next = scan_stopped;
    scan_mode_next    = scan_mode;
    if (c_go) begin
      if (c_last) begin
        scan_stopped_next = 1'b0;
        scan_mode_next    = lzsg_pkg::MODE_FAST;
      end else begin
        scan_stopped_next = res_stopped;
        scan_mode_next    = res_mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_stopped <= 1'b0;
      scan_mode    <= lzsg_pkg::MODE_FAST;
    end else begin
      scan_stopped <= scan_stopped_next;
      scan_mode    <= scan_mode_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= c_valid && c_last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && c_valid && c_last) begin
      m_tdata <= {{(lzsg_pkg::M_DATA_W-3){1'b0}}, res_mode, res_stopped};
    end
  end

endmodule

// File: design/lzsg_port_checker.sv
// lzsg_port_checker: port-level checks on the lidar zone speed guard result beats
// depends on lzsg_pkg; bound to lidar_zone_speed_guard below

module lzsg_port_checker (
  input logic                               clk,
  input logic                               rst,
  input logic [lzsg_pkg::M_DATA_W-1:0]      m_tdata,
  input logic                               m_tvalid,
  input logic                               m_tready
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // speed mode is a defined code
  a_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:1] == lzsg_pkg::MODE_FAST) ||
                 (m_tdata[2:1] == lzsg_pkg::MODE_NORMAL) ||
                 (m_tdata[2:1] == lzsg_pkg::MODE_SLOW))
    else $error("undefined speed mode");

  // a stopped scan always reports slow
  a_stop_slow: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[2:1] == lzsg_pkg::MODE_SLOW)
    else $error("runstop without slow mode");

endmodule

bind lidar_zone_speed_guard lzsg_port_checker u_lzsg_port_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

// File: tb/lidar_zone_speed_guard_tb.sv
`timescale 1ns / 100ps
// lidar_zone_speed_guard_tb: self-checking bench for the lidar zone speed guard
// drives sample beats and register writes, predicts each scan result, compares on m_tdata
// depends on lzsg_pkg and lidar_zone_speed_guard

module lidar_zone_speed_guard_tb;

  typedef struct {
    logic [15:0]        range_mm;
    logic               no_ret;
    logic signed [15:0] cos_a;
    logic signed [15:0] sin_a;
    logic               last;
  } sample_t;

  typedef struct {
    logic                  runstop;
    lzsg_pkg::speed_mode_t mode;
  } verdict_t;

  logic                            clk;
  logic                            rst;
  logic [lzsg_pkg::S_DATA_W-1:0]   s_tdata;
  logic                            s_tlast;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [lzsg_pkg::M_DATA_W-1:0]   m_tdata;
  logic                            m_tvalid;
  logic                            m_tready;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [lzsg_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [lzsg_pkg::CFG_DATA_W-1:0] cfg_data;

  lidar_zone_speed_guard uut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // zone settings as the block should hold them
  logic signed [lzsg_pkg::OFFS_W-1:0] offs_x;
  logic [lzsg_pkg::HALF_W-1:0]        stop_hx, stop_hy, slow_hx, slow_hy, norm_hx, norm_hy;
  logic [lzsg_pkg::UNC_W-1:0]         unc;

  // scan state as the block should hold it
  logic                  scan_stop_seen;
  lzsg_pkg::speed_mode_t scan_speed;

  verdict_t verdict_q[$];
  int       src_idle_pct;
  int       sink_stall_pct;
  int       n_samples;
  int       n_verdicts;
  int       n_cfg_writes;
  int       n_errors;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d scan results outstanding", verdict_q.size());
    $display("lidar_zone_speed_guard_tb: FAIL");
    $finish;
  end

  function automatic bit in_box(longint x, longint y, logic [lzsg_pkg::HALF_W-1:0] hx,
                                logic [lzsg_pkg::HALF_W-1:0] hy, bit closed);
    longint lx, ly;
    lx = longint'(hx);
    ly = longint'(hy);
    if (closed)
      return x >= -lx && x <= lx && y >= -ly && y <= ly;
    return x > -lx && x < lx && y > -ly && y < ly;
  endfunction

  // folds one sample into the scan state; returns 1 with the verdict on a last beat
  function automatic bit fold_sample(input sample_t smp, output verdict_t v);
    longint d, x, y;
    bit     usable;
    usable = !scan_stop_seen && !smp.no_ret && smp.range_mm >= lzsg_pkg::MIN_RANGE_MM &&
             smp.range_mm <= lzsg_pkg::IGNORE_RANGE_MM;
    if (usable) begin
      d = longint'(smp.range_mm) - longint'(unc);
      x = ((d * longint'(smp.cos_a)) >>> 15) + longint'(offs_x);
      y = (d * longint'(smp.sin_a)) >>> 15;
      if (in_box(x, y, stop_hx, stop_hy, 1'b1)) begin
        scan_stop_seen = 1'b1;
        scan_speed     = lzsg_pkg::MODE_SLOW;
      end else begin
        if (in_box(x, y, slow_hx, slow_hy, 1'b0))
          scan_speed = lzsg_pkg::MODE_SLOW;
        if (in_box(x, y, norm_hx, norm_hy, 1'b0) && scan_speed != lzsg_pkg::MODE_SLOW)
          scan_speed = lzsg_pkg::MODE_NORMAL;
      end
    end
    v.runstop = scan_stop_seen;
    v.mode    = scan_speed;
    if (!smp.last)
      return 1'b0;
    scan_stop_seen = 1'b0;
    scan_speed     = lzsg_pkg::MODE_FAST;
    return 1'b1;
  endfunction

  function automatic sample_t mk(logic [15:0] r, logic nr, logic signed [15:0] c,
                                 logic signed [15:0] s, logic l);
    sample_t smp;
    smp.range_mm = r;
    smp.no_ret   = nr;
    smp.cos_a    = c;
    smp.sin_a    = s;
    smp.last     = l;
    return smp;
  endfunction

  function automatic logic signed [15:0] rand_trig();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic sample_t rand_sample(logic l);
    sample_t smp;
    int      k;
    k = $urandom_range(99);
    if (k < 8)
      smp.range_mm = 16'($urandom_range(49));
    else if (k < 16)
      smp.range_mm = 16'($urandom_range(65535, 2001));
    else if (k < 20)
      case ($urandom_range(3))
        0: smp.range_mm = lzsg_pkg::MIN_RANGE_MM - 16'd1;
        1: smp.range_mm = lzsg_pkg::MIN_RANGE_MM;
        2: smp.range_mm = lzsg_pkg::IGNORE_RANGE_MM;
        default: smp.range_mm = lzsg_pkg::IGNORE_RANGE_MM + 16'd1;
      endcase
    else
      smp.range_mm = 16'($urandom_range(2000, 50));
    smp.no_ret = ($urandom_range(99) < 8);
    smp.cos_a  = rand_trig();
    smp.sin_a  = rand_trig();
    smp.last   = l;
    return smp;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_sample(input sample_t smp);
    verdict_t v;
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata  = lzsg_pkg::S_DATA_W'({$urandom, $urandom});
      s_tlast  = 1'($urandom_range(1));
      @(negedge clk);
    end
    s_tdata  = {7'b0, smp.sin_a, smp.cos_a, smp.no_ret, smp.range_mm};
    s_tlast  = smp.last;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    n_samples++;
    if (fold_sample(smp, v))
      verdict_q = {verdict_q, v};
    @(negedge clk);
  endtask

  // let the pipeline empty before touching the registers
  task automatic settle();
    s_tvalid = 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(input lzsg_pkg::cfg_reg_t idx,
                           input logic [lzsg_pkg::CFG_DATA_W-1:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    n_cfg_writes++;
    case (idx)
      lzsg_pkg::REG_LIDAR_OFFSET_X:    offs_x  = val[lzsg_pkg::OFFS_W-1:0];
      lzsg_pkg::REG_STOP_HALF_X:       stop_hx = val;
      lzsg_pkg::REG_STOP_HALF_Y:       stop_hy = val;
      lzsg_pkg::REG_SLOW_HALF_X:       slow_hx = val;
      lzsg_pkg::REG_SLOW_HALF_Y:       slow_hy = val;
      lzsg_pkg::REG_NORMAL_HALF_X:     norm_hx = val;
      lzsg_pkg::REG_NORMAL_HALF_Y:     norm_hy = val;
      lzsg_pkg::REG_RANGE_UNCERTAINTY: unc     = val[lzsg_pkg::UNC_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_zones(input logic [13:0] offs, input logic [13:0] shx,
                            input logic [13:0] shy, input logic [13:0] slx,
                            input logic [13:0] sly, input logic [13:0] nhx,
                            input logic [13:0] nhy, input logic [13:0] uncv);
    settle();
    cfg_write(lzsg_pkg::REG_LIDAR_OFFSET_X, offs);
    cfg_write(lzsg_pkg::REG_STOP_HALF_X, shx);
    cfg_write(lzsg_pkg::REG_STOP_HALF_Y, shy);
    cfg_write(lzsg_pkg::REG_SLOW_HALF_X, slx);
    cfg_write(lzsg_pkg::REG_SLOW_HALF_Y, sly);
    cfg_write(lzsg_pkg::REG_NORMAL_HALF_X, nhx);
    cfg_write(lzsg_pkg::REG_NORMAL_HALF_Y, nhy);
    cfg_write(lzsg_pkg::REG_RANGE_UNCERTAINTY, uncv);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [13:0] rand_half();
    case ($urandom_range(9))
      0: return 14'd0;
      1: return 14'h3fff;
      default: return 14'($urandom_range(2600));
    endcase
  endfunction

  task automatic randomise_zones();
    load_zones(14'($urandom_range(16383)), rand_half(), rand_half(), rand_half(),
               rand_half(), rand_half(), rand_half(),
               ($urandom_range(3) == 0) ? 14'($urandom_range(16383))
                                        : 14'($urandom_range(200)));
  endtask

  // reset settings: only the stop box is open, range limits and skipped samples
  task automatic test_reset_defaults();
    send_sample(mk(16'd0, 1'b0, 16'sh7fff, 16'sh0000, 1'b1));
    send_sample(mk(16'd49, 1'b0, 16'sh7fff, 16'sh0000, 1'b0));
    send_sample(mk(16'd2001, 1'b0, 16'sh7fff, 16'sh0000, 1'b0));
    send_sample(mk(16'hffff, 1'b0, 16'sh0000, 16'sh0000, 1'b0));
    send_sample(mk(16'd500, 1'b1, 16'sh7fff, 16'sh0000, 1'b0));
    send_sample(mk(16'd2000, 1'b0, 16'sh7fff, 16'sh7fff, 1'b0));
    send_sample(mk(16'd2000, 1'b0, 16'sh8000, 16'sh8000, 1'b1));
    // range under the uncertainty lands near the origin; later samples ignored
    send_sample(mk(16'd50, 1'b0, 16'sh7fff, 16'sh0000, 1'b0));
    send_sample(mk(16'd1000, 1'b0, 16'sh0000, 16'sh0000, 1'b0));
    send_sample(mk(16'hffff, 1'b1, 16'sh0000, 16'sh0000, 1'b1));
    // stop box edge is inclusive
    send_sample(mk(16'd883, 1'b0, 16'sh8000, 16'sh0000, 1'b1));
    send_sample(mk(16'd884, 1'b0, 16'sh8000, 16'sh0000, 1'b1));
  endtask

  // slow overrides normal, strict edges on slow and normal boxes
  task automatic test_zone_priority();
    load_zones(14'd0, 14'd100, 14'd100, 14'd400, 14'd400, 14'd1000, 14'd1000, 14'd0);
    send_sample(mk(16'd800, 1'b0, 16'sh7fff, 16'sh0000, 1'b0));
    send_sample(mk(16'd300, 1'b0, 16'sh7fff, 16'sh0000, 1'b0));
    send_sample(mk(16'd800, 1'b0, 16'sh7fff, 16'sh0000, 1'b1));
    send_sample(mk(16'd401, 1'b0, 16'sh7fff, 16'sh0000, 1'b1));
    send_sample(mk(16'd400, 1'b0, 16'sh7fff, 16'sh0000, 1'b1));
    send_sample(mk(16'd1001, 1'b0, 16'sh7fff, 16'sh0000, 1'b1));
    send_sample(mk(16'd101, 1'b0, 16'sh7fff, 16'sh0000, 1'b0));
    send_sample(mk(16'd2000, 1'b0, 16'sh7fff, 16'sh0000, 1'b1));
    send_sample(mk(16'd999, 1'b0, 16'sh0000, 16'sh8000, 1'b1));
    send_sample(mk(16'd1000, 1'b0, 16'sh0000, 16'sh8000, 1'b1));
  endtask

  // register extremes and masking of the unused data bits
  task automatic test_register_extremes();
    load_zones(14'h0fff, 14'h3fff, 14'h3fff, 14'h3fff, 14'h3fff, 14'h3fff, 14'h3fff,
               14'h3fff);
    send_sample(mk(16'd50, 1'b0, 16'sh7fff, 16'sh7fff, 1'b1));
    send_sample(mk(16'd2000, 1'b0, 16'sh8000, 16'sh7fff, 1'b1));
    load_zones(14'h3000, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'h3c00);
    send_sample(mk(16'd2000, 1'b0, 16'sh0000, 16'sh0000, 1'b1));
    load_zones(14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0);
    send_sample(mk(16'd1000, 1'b0, 16'sh0000, 16'sh0000, 1'b1));
  endtask

  // mostly whole scans, with the odd early last beat
  task automatic test_random_scans(input int n_items);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(14, 1);
      for (int i = 0; i < len; i++)
        send_sample(rand_sample((i == len - 1) || ($urandom_range(99) < 3)));
      sent += len;
    end
  endtask

  always @(negedge clk) begin
    if (sink_stall_pct != 0)
      m_tready = ($urandom_range(99) >= sink_stall_pct);
    else
      m_tready = 1'b1;
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result runstop=%0b mode=%0d", $time, m_tdata[0],
                 m_tdata[2:1]);
      end else begin
        want = verdict_q.pop_front();
        n_verdicts++;
        if (m_tdata[0] !== want.runstop) begin
          n_errors++;
          $display("%0t: runstop expected %0b actual %0b", $time, want.runstop, m_tdata[0]);
        end
        if (m_tdata[2:1] !== want.mode) begin
          n_errors++;
          $display("%0t: speed_mode expected %0d actual %0d", $time, want.mode,
                   m_tdata[2:1]);
        end
      end
    end
  end

  initial begin
    rst            = 1'b1;
    s_tdata        = '0;
    s_tlast        = 1'b0;
    s_tvalid       = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    n_samples      = 0;
    n_verdicts     = 0;
    n_cfg_writes   = 0;
    n_errors       = 0;
    offs_x         = lzsg_pkg::RST_LIDAR_OFFSET_X;
    stop_hx        = lzsg_pkg::RST_STOP_HALF_X;
    stop_hy        = lzsg_pkg::RST_STOP_HALF_Y;
    slow_hx        = lzsg_pkg::RST_SLOW_HALF_X;
    slow_hy        = lzsg_pkg::RST_SLOW_HALF_Y;
    norm_hx        = lzsg_pkg::RST_NORMAL_HALF_X;
    norm_hy        = lzsg_pkg::RST_NORMAL_HALF_Y;
    unc            = lzsg_pkg::RST_RANGE_UNCERTAINTY;
    scan_stop_seen = 1'b0;
    scan_speed     = lzsg_pkg::MODE_FAST;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_zone_priority();
    test_register_extremes();
    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = (p == 1) ? 53 : (p == 3) ? 24 : 0;
      sink_stall_pct = (p == 2) ? 53 : (p == 3) ? 24 : 0;
      for (int k = 0; k < 2; k++) begin
        randomise_zones();
        test_random_scans(156);
      end
    end

    settle();
    $display("ran %0d sample beats through %0d register writes", n_samples, n_cfg_writes);
    $display("checked %0d scan results across four idle and stall phases", n_verdicts);
    if (n_errors == 0)
      $display("lidar_zone_speed_guard_tb: PASS");
    else
      $display("lidar_zone_speed_guard_tb: FAIL");
    $finish;
  end

endmodule

// File: files.f
design/lzsg_pkg.sv
design/lidar_zone_speed_guard.sv
design/lzsg_port_checker.sv
tb/lidar_zone_speed_guard_tb.sv
